FILE: rtl/scan_packet_deframer_defines.svh
// ----------------------------------------------------------------------------
// Scan packet deframer assertion macros
// Shared helpers for the concurrent checks on the deframer ports.
// ----------------------------------------------------------------------------
`ifndef SCAN_PACKET_DEFRAMER_DEFINES_SVH
`define SCAN_PACKET_DEFRAMER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define SPD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scan_packet_deframer check failed");

// Check a property on every clock edge, reset included
`define SPD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("scan_packet_deframer check failed");

`endif

FILE: rtl/spd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan packet deframer package
// Phase and status codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package spd_pkg;

   // Parser phases
   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_LENGTH = 3'd1;
   localparam logic [2:0] PH_ANGLE  = 3'd2;
   localparam logic [2:0] PH_DIST   = 3'd3;
   localparam logic [2:0] PH_CHECK  = 3'd4;

   // Packet status codes
   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_OK   = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // Configuration register indexes
   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SYNC_SECOND = 2'd1;

   // Start pattern reset values
   localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

   // Result record for one received byte
   typedef struct packed {
      logic [1:0]  packet_status;
      logic        distance_valid;
      logic [15:0] distance_value;
      logic [15:0] distance_index;
      logic [15:0] start_angle;
      logic [15:0] point_count;
      logic [2:0]  parser_phase;
      logic [15:0] good_packets;
      logic [15:0] bad_packets;
   } result_type;

endpackage

FILE: rtl/spd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan packet parser
// Holds the framing state and builds one result record per received byte.
// ----------------------------------------------------------------------------
module spd_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             byte_take,
   input  logic [7:0]                       rx_byte,
   input  logic                             csr_we,
   input  logic [spd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [7:0]                       csr_wdata,
   output spd_pkg::result_type              result
);

   logic [7:0]  sync_first_ff,  sync_first_in;
   logic [7:0]  sync_second_ff, sync_second_in;
   logic [2:0]  phase_ff,       phase_in;
   logic        high_ff,        high_in;
   logic [7:0]  low_ff,         low_in;
   logic [15:0] length_ff,      length_in;
   logic [15:0] angle_ff,       angle_in;
   logic [15:0] index_ff,       index_in;
   logic [15:0] sum_ff,         sum_in;
   logic [15:0] ok_ff,          ok_in;
   logic [15:0] err_ff,         err_in;

   logic [15:0] word_w;
   logic [15:0] sum_add;
   logic [15:0] index_inc;
   logic [1:0]  status;
   logic        dvalid;
   logic [15:0] dvalue;
   logic [15:0] dindex;

   // Decode configuration writes; unknown indexes are dropped
   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_we) begin
         unique case (csr_addr)
            spd_pkg::CSR_SYNC_FIRST:  sync_first_in  = csr_wdata;
            spd_pkg::CSR_SYNC_SECOND: sync_second_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign word_w    = {rx_byte, low_ff};
   assign sum_add   = sum_ff + word_w;
   assign index_inc = index_ff + 16'd1;

   // Advance the framing state by one byte
   always_comb begin
      phase_in  = phase_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      length_in = length_ff;
      angle_in  = angle_ff;
      index_in  = index_ff;
      sum_in    = sum_ff;
      ok_in     = ok_ff;
      err_in    = err_ff;
      status    = spd_pkg::ST_NONE;
      dvalid    = 1'b0;
      dvalue    = 16'd0;
      dindex    = 16'd0;

      if (!high_ff) begin
         // low byte of a word, or first byte of the start pattern
         if (phase_ff inside {spd_pkg::PH_LENGTH, spd_pkg::PH_ANGLE,
                              spd_pkg::PH_DIST, spd_pkg::PH_CHECK}) begin
            low_in  = rx_byte;
            high_in = 1'b1;
            if (phase_ff == spd_pkg::PH_LENGTH) begin
               length_in = {8'd0, rx_byte};
            end else if (phase_ff == spd_pkg::PH_ANGLE) begin
               angle_in = {8'd0, rx_byte};
            end
         end else if (rx_byte == sync_first_ff) begin
            high_in = 1'b1;
         end
      end else begin
         high_in = 1'b0;
         unique case (phase_ff)
            spd_pkg::PH_LENGTH: begin
               length_in = word_w;
               sum_in    = sum_add;
               phase_in  = spd_pkg::PH_ANGLE;
            end
            spd_pkg::PH_ANGLE: begin
               angle_in = word_w;
               sum_in   = sum_add;
               // zero count skips straight to the checksum
               phase_in = (length_ff == 16'd0) ? spd_pkg::PH_CHECK : spd_pkg::PH_DIST;
            end
            spd_pkg::PH_DIST: begin
               sum_in   = sum_add;
               dvalid   = 1'b1;
               dvalue   = word_w;
               dindex   = index_ff;
               index_in = index_inc;
               if (index_inc == length_ff) begin
                  phase_in = spd_pkg::PH_CHECK;
               end
            end
            spd_pkg::PH_CHECK: begin
               if (word_w == sum_ff) begin
                  status = spd_pkg::ST_OK;
                  ok_in  = ok_ff + 16'd1;
               end else begin
                  status = spd_pkg::ST_BAD;
                  err_in = err_ff + 16'd1;
               end
               phase_in = spd_pkg::PH_HUNT;
            end
            default: begin
               // second byte of the start pattern; a miss resumes the hunt
               phase_in = spd_pkg::PH_HUNT;
               if (rx_byte == sync_second_ff) begin
                  phase_in  = spd_pkg::PH_LENGTH;
                  length_in = 16'd0;
                  angle_in  = 16'd0;
                  index_in  = 16'd0;
                  sum_in    = 16'd0;
               end
            end
         endcase
      end
   end

   // Build the result from the state after this byte
   always_comb begin
      result.packet_status  = status;
      result.distance_valid = dvalid;
      result.distance_value = dvalue;
      result.distance_index = dindex;
      result.start_angle    = angle_in;
      result.point_count    = length_in;
      result.parser_phase   = phase_in;
      result.good_packets   = ok_in;
      result.bad_packets    = err_in;
   end

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= spd_pkg::SYNC_FIRST_RST;
         sync_second_ff <= spd_pkg::SYNC_SECOND_RST;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   // Commit the framing state on each byte transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= spd_pkg::PH_HUNT;
         high_ff   <= 1'b0;
         low_ff    <= 8'd0;
         length_ff <= 16'd0;
         angle_ff  <= 16'd0;
         index_ff  <= 16'd0;
         sum_ff    <= 16'd0;
         ok_ff     <= 16'd0;
         err_ff    <= 16'd0;
      end else if (byte_take) begin
         phase_ff  <= phase_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
         length_ff <= length_in;
         angle_ff  <= angle_in;
         index_ff  <= index_in;
         sum_ff    <= sum_in;
         ok_ff     <= ok_in;
         err_ff    <= err_in;
      end
   end

endmodule

FILE: rtl/spd_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan packet result buffer
// Output register plus one skid entry so input and output stall independently.
// ----------------------------------------------------------------------------
module spd_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  spd_pkg::result_type push_data,
   output logic                space,
   output logic                out_valid,
   input  logic                out_ready,
   output spd_pkg::result_type out_data
);

   logic                out_valid_ff,  out_valid_in;
   spd_pkg::result_type out_data_ff,   out_data_in;
   logic                skid_valid_ff, skid_valid_in;
   spd_pkg::result_type skid_data_ff,  skid_data_in;
   logic                load_out;

   // Accept only while the skid entry is free
   assign space    = !skid_valid_ff;
   assign load_out = !out_valid_ff || out_ready;

   // Refill the output register from the skid entry first, else park in skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (load_out) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   // Hold the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

FILE: rtl/scan_packet_deframer.sv
`timescale 1ns / 1ps
// Takes one received byte per cycle while req_tready is high and gives exactly
// one result per byte, registered in the result buffer after the byte transfer.
// The next framing state is computed combinationally and committed on each byte
// transfer, so a new byte can be taken every clock; a two-entry result buffer
// lets the input take one more byte while the output stalls, after which
// req_tready drops until the consumer takes a result. The start pattern is set
// through csr_addr 0 (first byte) and 1 (second byte); write it only while the stream is idle.
// ----------------------------------------------------------------------------
// Scan packet deframer
// Byte-serial parser for sync, count, angle, distances and checksum.
// ----------------------------------------------------------------------------
module scan_packet_deframer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] rx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [15:0] distance_value, [31:16] distance_index, [47:32] start_angle,
   // [63:48] point_count, [66:64] parser_phase, [82:67] good_packets,
   // [98:83] bad_packets, [103:99] zero
   output logic [103:0]                   rsp_tdata,
   output logic [2:0]                     rsp_tuser,   // [1:0] packet_status, [2] distance_valid
   input  logic                           csr_we,
   input  logic [spd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [7:0]                     csr_wdata
);

   spd_pkg::result_type parse_result;
   spd_pkg::result_type out_result;
   logic                byte_take;
   logic                space;

   assign req_tready = space;
   assign byte_take  = req_tvalid && space;

   spd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .rx_byte   (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .result    (parse_result)
   );

   spd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (byte_take),
      .push_data (parse_result),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   // Pack the result record onto the stream
   assign rsp_tdata = {5'd0,
                       out_result.bad_packets,
                       out_result.good_packets,
                       out_result.parser_phase,
                       out_result.point_count,
                       out_result.start_angle,
                       out_result.distance_index,
                       out_result.distance_value};
   assign rsp_tuser = {out_result.distance_valid, out_result.packet_status};

endmodule

FILE: rtl/spd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan packet deframer checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "scan_packet_deframer_defines.svh"

module spd_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   logic [2:0] phase;
   logic [1:0] status;
   logic       dvalid;

   assign phase  = rsp_tdata[66:64];
   assign status = rsp_tuser[1:0];
   assign dvalid = rsp_tuser[2];

   // Stalled result holds its payload
   `SPD_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   // No result straight after reset
   `SPD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)
   // A distance is only finished inside the distance run
   `SPD_ASSERT(a_dist_phase, clock, reset, rsp_tvalid && dvalid |-> phase == spd_pkg::PH_DIST || phase == spd_pkg::PH_CHECK)
   // A checksum verdict closes the packet and carries no distance
   `SPD_ASSERT(a_verdict, clock, reset, rsp_tvalid && status != spd_pkg::ST_NONE |-> phase == spd_pkg::PH_HUNT && !dvalid)

endmodule

bind scan_packet_deframer spd_checker u_spd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: bench/tb_scan_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan packet deframer testbench
// Streams bytes into the deframer and checks every result record against a
// cycle-free model of the framing state, across several start patterns.
// Directed packets come first, then random packets, broken start patterns
// and noise. Both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_scan_packet_deframer;

   // Spare register slots, writes to them have no effect
   localparam logic [spd_pkg::CSR_ADDR_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [spd_pkg::CSR_ADDR_W-1:0] CSR_SPARE_B = 2'd3;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned SETTLE_TICKS = 8;
   localparam int unsigned PHASE_BYTES  = 230;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [spd_pkg::CSR_ADDR_W-1:0] csr_addr = spd_pkg::CSR_SYNC_FIRST;
   logic [7:0]   csr_wdata = 8'h00;

   // Start pattern as the block holds it
   logic [7:0]   cfg_sync_first  = spd_pkg::SYNC_FIRST_RST;
   logic [7:0]   cfg_sync_second = spd_pkg::SYNC_SECOND_RST;

   // Framing state of the predictor
   logic [2:0]   pred_phase     = spd_pkg::PH_HUNT;
   logic         pred_high_next = 1'b0;
   logic [7:0]   pred_low_hold  = 8'h00;
   logic [15:0]  pred_length    = 16'h0000;
   logic [15:0]  pred_angle     = 16'h0000;
   logic [15:0]  pred_index     = 16'h0000;
   logic [15:0]  pred_sum       = 16'h0000;
   logic [15:0]  pred_ok        = 16'h0000;
   logic [15:0]  pred_bad       = 16'h0000;

   logic [7:0]           byte_queue[$];
   spd_pkg::result_type  expected_results[$];
   int unsigned  pushed_count   = 0;
   int unsigned  accepted_count = 0;
   int unsigned  error_count    = 0;
   int unsigned  cycle_count    = 0;
   int unsigned  req_gap        = 0;
   int unsigned  rsp_gap        = 0;
   bit           req_taken      = 1'b0;
   bit           quiet_tail     = 1'b0;

   scan_packet_deframer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Advance the framing state by one byte and build its result record
   function automatic spd_pkg::result_type deframe_byte(input logic [7:0] rx);
      spd_pkg::result_type res;
      logic [15:0]         word;
      res = '0;
      if (!pred_high_next) begin
         // Low byte of a word, or a candidate first start byte
         if (pred_phase >= spd_pkg::PH_LENGTH && pred_phase <= spd_pkg::PH_CHECK) begin
            pred_low_hold  = rx;
            pred_high_next = 1'b1;
            if (pred_phase == spd_pkg::PH_LENGTH)
               pred_length = {8'h00, rx};
            else if (pred_phase == spd_pkg::PH_ANGLE)
               pred_angle = {8'h00, rx};
         end else if (rx == cfg_sync_first) begin
            pred_high_next = 1'b1;
         end
      end else begin
         pred_high_next = 1'b0;
         word = {rx, pred_low_hold};
         case (pred_phase)
            spd_pkg::PH_LENGTH: begin
               pred_length = word;
               pred_sum    = pred_sum + word;
               pred_phase  = spd_pkg::PH_ANGLE;
            end
            spd_pkg::PH_ANGLE: begin
               pred_angle = word;
               pred_sum   = pred_sum + word;
               pred_phase = (pred_length == 16'h0000) ? spd_pkg::PH_CHECK
                                                      : spd_pkg::PH_DIST;
            end
            spd_pkg::PH_DIST: begin
               pred_sum           = pred_sum + word;
               res.distance_valid = 1'b1;
               res.distance_value = word;
               res.distance_index = pred_index;
               pred_index         = pred_index + 16'd1;
               if (pred_index == pred_length)
                  pred_phase = spd_pkg::PH_CHECK;
            end
            spd_pkg::PH_CHECK: begin
               if (word == pred_sum) begin
                  res.packet_status = spd_pkg::ST_OK;
                  pred_ok           = pred_ok + 16'd1;
               end else begin
                  res.packet_status = spd_pkg::ST_BAD;
                  pred_bad          = pred_bad + 16'd1;
               end
               pred_phase = spd_pkg::PH_HUNT;
            end
            default: begin
               // Second start byte decides; a mismatch returns to the hunt
               pred_phase = spd_pkg::PH_HUNT;
               if (rx == cfg_sync_second) begin
                  pred_phase  = spd_pkg::PH_LENGTH;
                  pred_length = 16'h0000;
                  pred_angle  = 16'h0000;
                  pred_index  = 16'h0000;
                  pred_sum    = 16'h0000;
               end
            end
         endcase
      end
      res.start_angle  = pred_angle;
      res.point_count  = pred_length;
      res.parser_phase = pred_phase;
      res.good_packets = pred_ok;
      res.bad_packets  = pred_bad;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Drive the request side: one byte per transfer, random gaps in between
   always @(negedge clock) begin
      logic drive_valid;
      drive_valid = req_tvalid;
      if (reset) begin
         drive_valid = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         drive_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (byte_queue.size() > 0) begin
            req_tdata   <= byte_queue.pop_front();
            drive_valid = 1'b1;
            if (!quiet_tail && $urandom_range(0, 9) == 0)
               req_gap = $urandom_range(1, 12);
         end
      end
      req_taken  = 1'b0;
      req_tvalid <= drive_valid;
   end

   // Drive the result side ready with random stall bursts
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!reset && !quiet_tail && $urandom_range(0, 11) == 0)
            rsp_gap = $urandom_range(1, 12);
      end
   end

   // Check result transfers, then predict for the byte transfer of this edge
   always @(posedge clock) begin
      spd_pkg::result_type want;
      spd_pkg::result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.distance_value = rsp_tdata[15:0];
            got.distance_index = rsp_tdata[31:16];
            got.start_angle    = rsp_tdata[47:32];
            got.point_count    = rsp_tdata[63:48];
            got.parser_phase   = rsp_tdata[66:64];
            got.good_packets   = rsp_tdata[82:67];
            got.bad_packets    = rsp_tdata[98:83];
            got.packet_status  = rsp_tuser[1:0];
            got.distance_valid = rsp_tuser[2];
            if (expected_results.size() == 0) begin
               $error("result transfer with no byte outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("packet_status", 16'(want.packet_status),
                           16'(got.packet_status));
               check_field("distance_valid", 16'(want.distance_valid),
                           16'(got.distance_valid));
               check_field("distance_value", want.distance_value, got.distance_value);
               check_field("distance_index", want.distance_index, got.distance_index);
               check_field("start_angle", want.start_angle, got.start_angle);
               check_field("point_count", want.point_count, got.point_count);
               check_field("parser_phase", 16'(want.parser_phase),
                           16'(got.parser_phase));
               check_field("good_packets", want.good_packets, got.good_packets);
               check_field("bad_packets", want.bad_packets, got.bad_packets);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(deframe_byte(req_tdata));
            accepted_count++;
            req_taken = 1'b1;
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_scan_packet_deframer failed");
      $finish;
   end

   task automatic queue_byte(input logic [7:0] b);
      byte_queue.push_back(b);
      pushed_count++;
   endtask

   task automatic queue_word(input logic [15:0] w);
      queue_byte(w[7:0]);
      queue_byte(w[15:8]);
   endtask

   task automatic queue_header(input logic [15:0] count, input logic [15:0] angle);
      queue_byte(cfg_sync_first);
      queue_byte(cfg_sync_second);
      queue_word(count);
      queue_word(angle);
   endtask

   // Favor the extremes and words that look like the start pattern
   function automatic logic [15:0] pick_distance();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {cfg_sync_second, cfg_sync_first};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_packet(input logic [15:0] count, input logic [15:0] angle,
                               input bit corrupt);
      logic [15:0] sum;
      logic [15:0] dist_word;
      sum = count + angle;
      queue_header(count, angle);
      for (int unsigned i = 0; i < count; i++) begin
         dist_word = pick_distance();
         sum       = sum + dist_word;
         queue_word(dist_word);
      end
      if (corrupt)
         sum = sum + 16'($urandom_range(1, 65535));
      queue_word(sum);
   endtask

   // Random byte that can never open a start pattern
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom);
      while (b == cfg_sync_first)
         b = 8'($urandom);
      return b;
   endfunction

   // Hold until every byte has been taken and every result checked
   task automatic wait_drained();
      while (accepted_count != pushed_count || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(input logic [spd_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [7:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      if (addr == spd_pkg::CSR_SYNC_FIRST)
         cfg_sync_first = data;
      else if (addr == spd_pkg::CSR_SYNC_SECOND)
         cfg_sync_second = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed packets, with broken start patterns and noise mixed in
   task automatic run_random_phase(input int unsigned budget);
      int unsigned start;
      int unsigned pick;
      logic [15:0] count;
      logic [7:0]  b;
      start = pushed_count;
      while (pushed_count - start < budget) begin
         pick = $urandom_range(0, 19);
         if (pick <= 13 || (pick == 19 && $urandom_range(0, 3) != 0)) begin
            if ($urandom_range(0, 7) == 0)
               count = 16'($urandom_range(6, 24));
            else
               count = 16'($urandom_range(0, 5));
            queue_packet(count, 16'($urandom), $urandom_range(0, 4) == 0);
         end else if (pick <= 16) begin
            // First start byte followed by anything but the second
            queue_byte(cfg_sync_first);
            b = 8'($urandom);
            while (b == cfg_sync_second)
               b = 8'($urandom);
            queue_byte(b);
         end else if (pick <= 18) begin
            repeat ($urandom_range(1, 6)) queue_byte(noise_byte());
         end else begin
            wait_drained();
         end
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: broken start pattern whose second byte equals the first
      queue_byte(cfg_sync_first);
      queue_byte(cfg_sync_first);
      queue_byte(cfg_sync_second);
      // Zero count goes straight to the checksum
      queue_packet(16'h0000, 16'hFFFF, 1'b0);
      // One distance, bad checksum
      queue_packet(16'h0001, 16'h0000, 1'b1);
      wait_drained();

      run_random_phase(PHASE_BYTES);
      wait_drained();

      write_csr(spd_pkg::CSR_SYNC_FIRST, 8'h00);
      write_csr(spd_pkg::CSR_SYNC_SECOND, 8'hFF);
      write_csr(CSR_SPARE_A, 8'($urandom));
      run_random_phase(PHASE_BYTES);
      wait_drained();

      write_csr(spd_pkg::CSR_SYNC_FIRST, 8'hFF);
      write_csr(spd_pkg::CSR_SYNC_SECOND, 8'h00);
      write_csr(CSR_SPARE_B, 8'($urandom));
      run_random_phase(PHASE_BYTES);
      wait_drained();

      write_csr(spd_pkg::CSR_SYNC_FIRST, 8'($urandom));
      write_csr(spd_pkg::CSR_SYNC_SECOND, 8'($urandom));
      run_random_phase(PHASE_BYTES);
      wait_drained();

      // Identical start bytes
      write_csr(spd_pkg::CSR_SYNC_FIRST, 8'h7E);
      write_csr(spd_pkg::CSR_SYNC_SECOND, 8'h7E);
      run_random_phase(PHASE_BYTES);
      wait_drained();

      // Back to reset pattern, full rate on both sides
      write_csr(spd_pkg::CSR_SYNC_FIRST, spd_pkg::SYNC_FIRST_RST);
      write_csr(spd_pkg::CSR_SYNC_SECOND, spd_pkg::SYNC_SECOND_RST);
      quiet_tail = 1'b1;
      run_random_phase(PHASE_BYTES / 2);
      // Largest count, left open with random distances
      queue_header(16'hFFFF, 16'($urandom));
      repeat (60) queue_word(pick_distance());
      wait_drained();

      if (error_count == 0)
         $display("tb_scan_packet_deframer passed");
      else
         $display("tb_scan_packet_deframer failed");
      $finish;
   end

endmodule
